/* rtl/core/pssv_pkg.sv */
package pssv_pkg;

   // Defaults for the top-level parameters
   localparam int LINE_LENGTH_DEF = 30;
   localparam int VOICES_DEF      = 2;

   // Field widths
   localparam int OP_W       = 2;
   localparam int IDX_W      = 5;
   localparam int SAMPLE_W   = 16;
   localparam int DECAY_W    = 7;
   localparam int PERIOD_W   = 16;
   localparam int ENABLE_W   = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // Decay arithmetic: |line| * decay, then divide by 100 through a reciprocal.
   // floor(n * ceil(2^29 / 100) / 2^29) equals n / 100 for every n below 6.1e6.
   localparam int MAG_W       = SAMPLE_W + DECAY_W;
   localparam int RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd5368710;
   localparam int RECIP_SHIFT = 29;
   localparam int QUO_W       = 17;

   // Response queue depth, a power of two
   localparam int RSP_DEPTH = 8;

   // Register reset values
   localparam logic [DECAY_W-1:0]  DECAY_RESET   = 7'd97;
   localparam logic [PERIOD_W-1:0] PERIOD0_RESET = 16'd24;
   localparam logic [PERIOD_W-1:0] PERIOD1_RESET = 16'd96;
   localparam logic [ENABLE_W-1:0] ENABLE_RESET  = 2'b11;

   // Saturation bounds
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_PLUCK = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DECAY   = 2'd0,
      CSR_PERIOD0 = 2'd1,
      CSR_PERIOD1 = 2'd2,
      CSR_ENABLE  = 2'd3
   } csr_addr_type;

   // What a voice would do on the next tick
   typedef struct packed {
      logic step;
      logic first;
   } voice_cmd_type;

   // Operation entering a voice lane on an accepted beat
   typedef struct packed {
      logic step;
      logic first;
      logic pluck;
   } lane_op_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } rsp_type;

endpackage

/* rtl/core/pssv_if.sv */
interface pssv_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [pssv_pkg::OP_W-1:0]            operation;
   logic [pssv_pkg::IDX_W-1:0]           entry_index;
   logic signed [pssv_pkg::SAMPLE_W-1:0] entry_value;

   modport source (output valid, operation, entry_index, entry_value, input ready);
   modport sink   (input valid, operation, entry_index, entry_value, output ready);
endinterface

interface pssv_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pssv_pkg::SAMPLE_W-1:0] sample;
   logic                                 clipped;

   modport source (output valid, sample, clipped, input ready);
   modport sink   (input valid, sample, clipped, output ready);
endinterface

interface pssv_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pssv_pkg::CSR_ADDR_W-1:0]   addr;
   logic [pssv_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/core/plucked_string_voice_synth.sv */
// A tick beat's result passes lane stages 1 to 3 and the stage 4 sum before the queue offers it.
// Throughput: one beat per cycle; one state-memory read and write-back per voice per cycle.
// A beat waits only when a voice revisits a line entry whose write-back is still in
// flight (line length of two at a hold period of one), or the 8-entry response queue lacks
// room for the results in flight. Synchronous reset restores the registers (97, 24, 96, 3) and
// unplucked silent voices; excitation and delay line memories keep their contents.
module plucked_string_voice_synth #(
   parameter int LINE_LENGTH = pssv_pkg::LINE_LENGTH_DEF,
   parameter int VOICES      = pssv_pkg::VOICES_DEF
) (
   input logic        clock,
   input logic        reset,
   pssv_req_if.sink   req_chan,
   pssv_rsp_if.source rsp_chan,
   pssv_csr_if.sink   csr_chan
);
   import pssv_pkg::*;

   localparam int AddrW = $clog2(LINE_LENGTH);
   localparam int SumW  = SAMPLE_W + $clog2(VOICES) + 1;
   localparam int CntW  = $clog2(RSP_DEPTH) + 1;

   // Configuration registers
   logic [DECAY_W-1:0]  decay_ff;
   logic [PERIOD_W-1:0] period0_ff;
   logic [PERIOD_W-1:0] period1_ff;
   logic [ENABLE_W-1:0] enable_ff;

   logic accept, is_load, is_tick, is_pluck;
   logic load_ok;
   logic tick_s1_ff, tick_s2_ff, tick_s3_ff, tick_s4_ff;
   logic [CntW-1:0] fifo_count;
   logic [CntW-1:0] pending;
   logic [VOICES-1:0] hazard;

   logic [PERIOD_W-1:0]        period [VOICES];
   voice_cmd_type              cmd [VOICES];
   lane_op_type                lane_op [VOICES];
   logic [AddrW-1:0]           addr [VOICES];
   logic signed [SAMPLE_W-1:0] exc_data [VOICES];
   logic signed [SAMPLE_W-1:0] held [VOICES];

   logic signed [SumW-1:0] sum_in;
   rsp_type                push_data;

   // Write configuration; the port never stalls
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff   <= DECAY_RESET;
         period0_ff <= PERIOD0_RESET;
         period1_ff <= PERIOD1_RESET;
         enable_ff  <= ENABLE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_addr_type'(csr_chan.addr))
            CSR_DECAY:   decay_ff   <= csr_chan.data[DECAY_W-1:0];
            CSR_PERIOD0: period0_ff <= csr_chan.data[PERIOD_W-1:0];
            CSR_PERIOD1: period1_ff <= csr_chan.data[PERIOD_W-1:0];
            CSR_ENABLE:  enable_ff  <= csr_chan.data[ENABLE_W-1:0];
         endcase
      end
   end

   // Take a beat when the queue has room for every result in flight and no lane holds a hazard
   always_comb begin
      pending = fifo_count + CntW'(tick_s1_ff) + CntW'(tick_s2_ff) + CntW'(tick_s3_ff) +
                CntW'(tick_s4_ff);
      req_chan.ready = (pending < CntW'(RSP_DEPTH)) && (hazard == '0);
      accept   = req_chan.valid && req_chan.ready;
      is_load  = req_chan.operation == OP_LOAD;
      is_pluck = req_chan.operation == OP_PLUCK;
      is_tick  = req_chan.operation == OP_TICK;
      load_ok  = 32'(req_chan.entry_index) < LINE_LENGTH;
      for (int v = 0; v < VOICES; v++) begin
         period[v]        = (v == 0) ? period0_ff : period1_ff;
         lane_op[v].step  = accept && is_tick && cmd[v].step;
         lane_op[v].first = cmd[v].first;
         lane_op[v].pluck = accept && is_pluck;
      end
   end

   pssv_voice_ctl #(
      .LINE_LENGTH (LINE_LENGTH),
      .VOICES      (VOICES)
   ) u_voice_ctl (
      .clock        (clock),
      .reset        (reset),
      .tick_accept  (accept && is_tick),
      .pluck_accept (accept && is_pluck),
      .period       (period),
      .cmd          (cmd),
      .addr         (addr)
   );

   pssv_exc_mem #(
      .LINE_LENGTH (LINE_LENGTH),
      .VOICES      (VOICES)
   ) u_exc_mem (
      .clock   (clock),
      .wr_en   (accept && is_load && load_ok),
      .wr_addr (AddrW'(req_chan.entry_index)),
      .wr_data (req_chan.entry_value),
      .rd_en   (accept),
      .rd_addr (addr),
      .rd_data (exc_data)
   );

   for (genvar v = 0; v < VOICES; v++) begin : g_lane
      pssv_voice_lane #(
         .LINE_LENGTH (LINE_LENGTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .op_in      (lane_op[v]),
         .cmd_in     (cmd[v]),
         .addr_in    (addr[v]),
         .exc_data   (exc_data[v]),
         .decay      (decay_ff),
         .hazard     (hazard[v]),
         .held_value (held[v])
      );
   end

   // Track which stages carry a tick
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_s1_ff <= 1'b0;
         tick_s2_ff <= 1'b0;
         tick_s3_ff <= 1'b0;
         tick_s4_ff <= 1'b0;
      end else begin
         tick_s1_ff <= accept && is_tick;
         tick_s2_ff <= tick_s1_ff;
         tick_s3_ff <= tick_s2_ff;
         tick_s4_ff <= tick_s3_ff;
      end
   end

   // Stage 4: sum the enabled voices and saturate
   always_comb begin
      sum_in = '0;
      for (int v = 0; v < VOICES; v++) begin
         if (enable_ff[v]) begin
            sum_in = sum_in + SumW'(held[v]);
         end
      end
      push_data.clipped = (sum_in > SumW'(SAMPLE_MAX)) || (sum_in < SumW'(SAMPLE_MIN));
      if (sum_in > SumW'(SAMPLE_MAX)) begin
         push_data.sample = SAMPLE_MAX;
      end else if (sum_in < SumW'(SAMPLE_MIN)) begin
         push_data.sample = SAMPLE_MIN;
      end else begin
         push_data.sample = SAMPLE_W'(sum_in);
      end
   end

   pssv_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tick_s4_ff),
      .push_data (push_data),
      .rsp_chan  (rsp_chan),
      .count     (fifo_count)
   );

   // Results in flight plus queued never exceed the queue
   a_credit: assert property (@(posedge clock) disable iff (reset)
      pending <= CntW'(RSP_DEPTH))
      else $error("more results in flight than queue entries");

endmodule

/* rtl/core/pssv_voice_ctl.sv */
module pssv_voice_ctl #(
   parameter int LINE_LENGTH = pssv_pkg::LINE_LENGTH_DEF,
   parameter int VOICES      = pssv_pkg::VOICES_DEF,
   localparam int AddrW      = $clog2(LINE_LENGTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_accept,
   input  logic                          pluck_accept,
   input  logic [pssv_pkg::PERIOD_W-1:0] period [VOICES],
   output pssv_pkg::voice_cmd_type       cmd [VOICES],
   output logic [AddrW-1:0]              addr [VOICES]
);
   import pssv_pkg::*;

   localparam int PosW = AddrW + 1;

   logic [AddrW-1:0]    pos_ff [VOICES];
   logic [AddrW-1:0]    pos_in [VOICES];
   logic [PERIOD_W-1:0] count_ff [VOICES];
   logic [PERIOD_W-1:0] count_in [VOICES];
   logic [VOICES-1:0]   first_ff;
   logic [VOICES-1:0]   first_in;
   logic                plucked_ff;
   logic                plucked_in;

   logic [PERIOD_W-1:0] per_eff [VOICES];
   logic [PERIOD_W-1:0] hc [VOICES];
   logic [PosW-1:0]     pos_inc [VOICES];
   logic [PERIOD_W:0]   cnt_inc [VOICES];
   logic [VOICES-1:0]   wrap;

   // Decide each voice's step; advance its position and hold counter on a tick, restart on a pluck
   always_comb begin
      plucked_in = plucked_ff | pluck_accept;
      for (int v = 0; v < VOICES; v++) begin
         per_eff[v] = (period[v] == '0) ? PERIOD_W'(1) : period[v];
         hc[v]      = (count_ff[v] >= per_eff[v]) ? '0 : count_ff[v];
         pos_inc[v] = {1'b0, pos_ff[v]} + PosW'(1);
         wrap[v]    = pos_inc[v] >= PosW'(LINE_LENGTH);
         cnt_inc[v] = {1'b0, hc[v]} + (PERIOD_W + 1)'(1);

         cmd[v].step  = plucked_ff && (hc[v] == '0);
         cmd[v].first = first_ff[v];
         addr[v]      = pos_ff[v];

         pos_in[v]   = pos_ff[v];
         count_in[v] = count_ff[v];
         first_in[v] = first_ff[v];
         if (pluck_accept) begin
            pos_in[v]   = '0;
            count_in[v] = '0;
            first_in[v] = 1'b1;
         end else if (tick_accept && plucked_ff) begin
            if (hc[v] == '0) begin
               pos_in[v] = wrap[v] ? '0 : pos_inc[v][AddrW-1:0];
               if (wrap[v]) begin
                  first_in[v] = 1'b0;
               end
            end
            count_in[v] = (cnt_inc[v] >= {1'b0, per_eff[v]}) ? '0 : cnt_inc[v][PERIOD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plucked_ff <= 1'b0;
         first_ff   <= '1;
         for (int v = 0; v < VOICES; v++) begin
            pos_ff[v]   <= '0;
            count_ff[v] <= '0;
         end
      end else begin
         plucked_ff <= plucked_in;
         first_ff   <= first_in;
         for (int v = 0; v < VOICES; v++) begin
            pos_ff[v]   <= pos_in[v];
            count_ff[v] <= count_in[v];
         end
      end
   end

   // A pluck leaves every voice armed at the start of its first pass
   a_pluck_restart: assert property (@(posedge clock) disable iff (reset)
      pluck_accept |=> (plucked_ff && (first_ff == '1)))
      else $error("voices not restarted after pluck");

   for (genvar v = 0; v < VOICES; v++) begin : g_chk
      a_pos_range: assert property (@(posedge clock) disable iff (reset)
         {1'b0, pos_ff[v]} < PosW'(LINE_LENGTH))
         else $error("line position out of range");
   end

endmodule

/* rtl/core/pssv_exc_mem.sv */
module pssv_exc_mem #(
   parameter int LINE_LENGTH = pssv_pkg::LINE_LENGTH_DEF,
   parameter int VOICES      = pssv_pkg::VOICES_DEF,
   localparam int AddrW      = $clog2(LINE_LENGTH)
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AddrW-1:0]                     wr_addr,
   input  logic signed [pssv_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                 rd_en,
   input  logic [AddrW-1:0]                     rd_addr [VOICES],
   output logic signed [pssv_pkg::SAMPLE_W-1:0] rd_data [VOICES]
);
   import pssv_pkg::*;

   logic signed [SAMPLE_W-1:0] exc_mem [LINE_LENGTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff [VOICES];

   // One write port, one read port per voice, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         exc_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         for (int v = 0; v < VOICES; v++) begin
            rd_data_ff[v] <= exc_mem[rd_addr[v]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pssv_voice_lane.sv */
module pssv_voice_lane #(
   parameter int LINE_LENGTH = pssv_pkg::LINE_LENGTH_DEF,
   localparam int AddrW      = $clog2(LINE_LENGTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pssv_pkg::lane_op_type                op_in,
   input  pssv_pkg::voice_cmd_type              cmd_in,
   input  logic [AddrW-1:0]                     addr_in,
   input  logic signed [pssv_pkg::SAMPLE_W-1:0] exc_data,
   input  logic [pssv_pkg::DECAY_W-1:0]         decay,
   output logic                                 hazard,
   output logic signed [pssv_pkg::SAMPLE_W-1:0] held_value
);
   import pssv_pkg::*;

   localparam int RecipProdW = MAG_W + RECIP_W;

   logic signed [SAMPLE_W-1:0] line_mem [LINE_LENGTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;

   lane_op_type                s1_op_ff, s2_op_ff, s3_op_ff;
   logic [AddrW-1:0]           s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic signed [SAMPLE_W-1:0] s2_exc_ff, s3_exc_ff;
   logic [MAG_W-1:0]           s2_mag_ff, s2_mag_in;
   logic                       s2_neg_ff, s2_neg_in, s3_neg_ff;
   logic [QUO_W-1:0]           s3_quo_ff, s3_quo_in;
   logic                       wb_valid_ff;
   logic [AddrW-1:0]           wb_addr_ff;
   logic signed [SAMPLE_W-1:0] wb_data_ff, wb_data_in;
   logic signed [SAMPLE_W-1:0] held_ff, held_in;

   logic signed [SAMPLE_W-1:0] line_val;
   logic [SAMPLE_W-1:0]        line_abs;
   logic [RecipProdW-1:0]      recip_prod;
   logic signed [SAMPLE_W-1:0] decayed;

   // Hold the beat while an older step to the same entry has not reached write-back
   assign hazard = cmd_in.step && !cmd_in.first &&
                   ((s1_op_ff.step && (s1_addr_ff == addr_in)) ||
                    (s2_op_ff.step && (s2_addr_ff == addr_in)));

   // Stage 1: take the entry, bypassing the write that landed on the read edge, and scale by decay
   always_comb begin
      line_val  = (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) ? wb_data_ff : rdata_ff;
      line_abs  = line_val[SAMPLE_W-1] ? SAMPLE_W'(-line_val) : SAMPLE_W'(line_val);
      s2_neg_in = line_val[SAMPLE_W-1];
      s2_mag_in = MAG_W'(line_abs) * MAG_W'(decay);
   end

   // Stage 2: divide the magnitude by 100
   always_comb begin
      recip_prod = RecipProdW'(s2_mag_ff) * RecipProdW'(RECIP_MULT);
      s3_quo_in  = recip_prod[RECIP_SHIFT +: QUO_W];
   end

   // Stage 3: restore sign, saturate, pick the value to write back and the held value
   always_comb begin
      if (s3_neg_ff) begin
         decayed = (s3_quo_ff > QUO_W'({1'b0, SAMPLE_MIN})) ? SAMPLE_MIN
                                                            : SAMPLE_W'(-s3_quo_ff);
      end else begin
         decayed = (s3_quo_ff > QUO_W'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(s3_quo_ff);
      end
      wb_data_in = s3_op_ff.first ? s3_exc_ff : decayed;

      priority if (s3_op_ff.pluck) begin
         held_in = '0;
      end else if (s3_op_ff.step) begin
         held_in = s3_op_ff.first ? '0 : decayed;
      end else begin
         held_in = held_ff;
      end
   end

   // Delay line memory: read on an accepted stepping tick, write back from stage 3
   always_ff @(posedge clock) begin
      if (s3_op_ff.step) begin
         line_mem[s3_addr_ff] <= wb_data_in;
      end
      if (op_in.step) begin
         rdata_ff <= line_mem[addr_in];
      end
   end

   // Advance control through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff    <= '0;
         s2_op_ff    <= '0;
         s3_op_ff    <= '0;
         wb_valid_ff <= 1'b0;
         held_ff     <= '0;
      end else begin
         s1_op_ff    <= op_in;
         s2_op_ff    <= s1_op_ff;
         s3_op_ff    <= s2_op_ff;
         wb_valid_ff <= s3_op_ff.step;
         held_ff     <= held_in;
      end
   end

   // Advance payload through the stages
   always_ff @(posedge clock) begin
      s1_addr_ff <= addr_in;
      s2_addr_ff <= s1_addr_ff;
      s3_addr_ff <= s2_addr_ff;
      s2_exc_ff  <= exc_data;
      s3_exc_ff  <= s2_exc_ff;
      s2_mag_ff  <= s2_mag_in;
      s2_neg_ff  <= s2_neg_in;
      s3_neg_ff  <= s2_neg_ff;
      s3_quo_ff  <= s3_quo_in;
      wb_addr_ff <= s3_addr_ff;
      wb_data_ff <= wb_data_in;
   end

   assign held_value = held_ff;

   // A decaying read never overlaps a pending write to the same entry
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_op_ff.step && !s1_op_ff.first) |->
         !((s2_op_ff.step && (s2_addr_ff == s1_addr_ff)) ||
           (s3_op_ff.step && (s3_addr_ff == s1_addr_ff))))
      else $error("line read overlaps a pending write");

endmodule

/* rtl/core/pssv_rsp_fifo.sv */
module pssv_rsp_fifo (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  pssv_pkg::rsp_type                      push_data,
   pssv_rsp_if.source                             rsp_chan,
   output logic [$clog2(pssv_pkg::RSP_DEPTH):0]   count
);
   import pssv_pkg::*;

   localparam int PtrW = $clog2(RSP_DEPTH);

   rsp_type         queue_ff [RSP_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            pop;

   // Show the oldest result and drop it when the beat is taken
   always_comb begin
      rsp_chan.valid   = count_ff != '0;
      rsp_chan.sample  = queue_ff[rd_ptr_ff].sample;
      rsp_chan.clipped = queue_ff[rd_ptr_ff].clipped;
      pop       = rsp_chan.valid && rsp_chan.ready;
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < (PtrW + 1)'(RSP_DEPTH) || pop))
      else $error("response queue overflow");

endmodule

/* tb/sv/plucked_string_voice_synth_test.sv */
module plucked_string_voice_synth_test;
   import pssv_pkg::*;

   localparam int LINE          = LINE_LENGTH_DEF;
   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT   = 2000;

   // Operation code the block drops without a result
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct {
      bit                         is_reg;
      csr_addr_type               reg_addr;
      logic [CSR_DATA_W-1:0]      reg_data;
      logic [OP_W-1:0]            op;
      logic [IDX_W-1:0]           idx;
      logic signed [SAMPLE_W-1:0] val;
      int                         count;
      bit                         pinned;
      rsp_type                    want;
   } plan_row_type;

   logic clock;
   logic reset;

   pssv_req_if req_chan ();
   pssv_rsp_if rsp_chan ();
   pssv_csr_if csr_chan ();

   plucked_string_voice_synth DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Voice model state and register shadow
   logic signed [SAMPLE_W-1:0] excitation [LINE];
   logic signed [SAMPLE_W-1:0] string_line [VOICES_DEF][LINE];
   int                         line_pos [VOICES_DEF];
   int                         hold_cnt [VOICES_DEF];
   bit                         first_lap [VOICES_DEF];
   int                         held [VOICES_DEF];
   bit                         plucked_now;
   logic [DECAY_W-1:0]         decay_pct;
   logic [PERIOD_W-1:0]        hold_period [VOICES_DEF];
   logic [ENABLE_W-1:0]        voice_on;

   rsp_type      due_samples [$];
   plan_row_type plan [$];
   int           mismatches;
   int           idle_cycles;
   int           stall_left;
   int           idle_pct;
   int           stall_pct;
   bit           calm;
   bit           pin_now;
   rsp_type      pin_want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void restart_voices();
      for (int v = 0; v < VOICES_DEF; v++) begin
         line_pos[v]  = 0;
         hold_cnt[v]  = 0;
         first_lap[v] = 1'b1;
         held[v]      = 0;
      end
   endfunction

   // Advance one voice by one tick; step the line when its hold count wraps
   function automatic void step_voice(int v);
      int period;
      int p;
      int prod;
      period = int'(hold_period[v]);
      if (period == 0) period = 1;
      if (hold_cnt[v] >= period) hold_cnt[v] = 0;
      if (hold_cnt[v] == 0) begin
         p = line_pos[v];
         if (p >= LINE) p = 0;
         if (first_lap[v]) begin
            string_line[v][p] = excitation[p];
            held[v] = 0;
         end else begin
            prod = int'(string_line[v][p]) * int'(decay_pct);
            held[v] = clamp16(prod / 100);
            string_line[v][p] = SAMPLE_W'(held[v]);
         end
         p++;
         if (p >= LINE) begin
            p = 0;
            first_lap[v] = 1'b0;
         end
         line_pos[v] = p;
      end
      hold_cnt[v]++;
      if (hold_cnt[v] >= period) hold_cnt[v] = 0;
   endfunction

   function automatic rsp_type tick_sample();
      int      total;
      rsp_type r;
      total = 0;
      if (plucked_now) begin
         for (int v = 0; v < VOICES_DEF; v++) begin
            step_voice(v);
            if (voice_on[v]) total += held[v];
         end
      end
      r.sample  = SAMPLE_W'(clamp16(total));
      r.clipped = (clamp16(total) != total);
      return r;
   endfunction

   // Apply one accepted beat; return 1 when it yields a sample
   function automatic bit take_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                    logic signed [SAMPLE_W-1:0] val, output rsp_type r);
      r = '0;
      case (op)
         OP_LOAD: begin
            if (idx < LINE) excitation[idx] = val;
            return 1'b0;
         end
         OP_PLUCK: begin
            restart_voices();
            plucked_now = 1'b1;
            return 1'b0;
         end
         OP_TICK: begin
            r = tick_sample();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void flag_fault(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
   endfunction

   function automatic plan_row_type beat_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic signed [SAMPLE_W-1:0] val, int count,
                                             bit pinned, logic signed [SAMPLE_W-1:0] sample,
                                             logic clipped);
      plan_row_type r;
      r.is_reg       = 1'b0;
      r.reg_addr     = CSR_DECAY;
      r.reg_data     = '0;
      r.op           = op;
      r.idx          = idx;
      r.val          = val;
      r.count        = count;
      r.pinned       = pinned;
      r.want.sample  = sample;
      r.want.clipped = clipped;
      return r;
   endfunction

   function automatic plan_row_type reg_row(csr_addr_type addr,
                                            logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r          = beat_row(OP_TICK, '0, '0, 0, 1'b0, '0, 1'b0);
      r.is_reg   = 1'b1;
      r.reg_addr = addr;
      r.reg_data = data;
      return r;
   endfunction

   // Observe all three channels, keep the model in step and check samples
   always @(posedge clock) begin : monitor
      rsp_type due;
      rsp_type got;
      bit      moved;
      if (reset) begin
         decay_pct      = DECAY_RESET;
         hold_period[0] = PERIOD0_RESET;
         hold_period[1] = PERIOD1_RESET;
         voice_on       = ENABLE_RESET;
         restart_voices();
         plucked_now = 1'b0;
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_chan.valid && csr_chan.ready) begin
            moved = 1'b1;
            case (csr_addr_type'(csr_chan.addr))
               CSR_DECAY:   decay_pct      = csr_chan.data[DECAY_W-1:0];
               CSR_PERIOD0: hold_period[0] = csr_chan.data[PERIOD_W-1:0];
               CSR_PERIOD1: hold_period[1] = csr_chan.data[PERIOD_W-1:0];
               CSR_ENABLE:  voice_on       = csr_chan.data[ENABLE_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            if (take_beat(req_chan.operation, req_chan.entry_index, req_chan.entry_value, due))
               due_samples.push_back(pin_now ? pin_want : due);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            got.sample  = rsp_chan.sample;
            got.clipped = rsp_chan.clipped;
            if (due_samples.size() == 0) begin
               flag_fault($sformatf("sample %0d/%0b with none pending", got.sample,
                                    got.clipped));
            end else begin
               due = due_samples.pop_front();
               if (due.sample !== got.sample || due.clipped !== got.clipped)
                  flag_fault($sformatf("sample/clipped expected %0d/%0b, got %0d/%0b",
                                       due.sample, due.clipped, got.sample, got.clipped));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("plucked_string_voice_synth_test: errors");
            $finish;
         end
      end
   end

   // Throttle the sample channel in random bursts
   always @(posedge clock) begin : receiver
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 13);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Offer one beat, hold it until taken, then maybe pause
   task automatic send_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                            logic signed [SAMPLE_W-1:0] val, bit pinned, rsp_type want);
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.entry_index <= idx;
      req_chan.entry_value <= val;
      pin_now              <= pinned;
      pin_want             <= want;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic write_reg(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= addr;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain every pending sample, then let the pipeline empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly ticks, some table loads and plucks, a little ignored traffic
   task automatic play_random(int n);
      int                         done_n;
      int                         r;
      logic [IDX_W-1:0]           idx;
      logic signed [SAMPLE_W-1:0] val;
      done_n = 0;
      while (done_n < n) begin
         r   = $urandom_range(0, 99);
         idx = IDX_W'($urandom_range(0, 31));
         val = SAMPLE_W'($urandom_range(0, 65535));
         if (r < 2) begin
            send_beat(OP_PLUCK, idx, val, 1'b0, '0);
            done_n++;
         end else if (r < 4) begin
            send_beat(OP_SPARE, idx, val, 1'b0, '0);
         end else if (r < 18) begin
            send_beat(OP_LOAD, idx, val, 1'b0, '0);
            if (idx < LINE) done_n++;
         end else begin
            send_beat(OP_TICK, idx, val, 1'b0, '0);
            done_n++;
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] set_decay;
      logic [CSR_DATA_W-1:0] set_p0;
      logic [CSR_DATA_W-1:0] set_p1;
      logic [CSR_DATA_W-1:0] set_en;
      bit                    replay;

      idle_pct    = 15;
      stall_pct   = 15;
      calm        = 1'b0;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_TICK;
      req_chan.entry_index <= '0;
      req_chan.entry_value <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.addr        <= CSR_DECAY;
      csr_chan.data        <= '0;
      pin_now              <= 1'b0;
      pin_want             <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole excitation table before any voice can read it
      for (int i = 0; i < LINE; i++)
         send_beat(OP_LOAD, IDX_W'(i), SAMPLE_W'($urandom_range(0, 65535)), 1'b0, '0);

      // Directed rows: unplucked silence, ignored beats, first pass, clipping, zero decay
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     1, 1'b1, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_SPARE, 5'd5,  16'sd1234,  1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_LOAD,  5'd31, 16'sh7FFF,  1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_LOAD,  5'd30, -16'sd1,    1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_LOAD,  5'd0,  16'sh7FFF,  1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_LOAD,  5'd1,  16'sh7FFF,  1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_LOAD,  5'd2,  16'sh8000,  1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_LOAD,  5'd29, 16'sh8000,  1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     1, 1'b1, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_PLUCK, 5'd0,  16'sd0,     1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     4, 1'b1, 16'sd0, 1'b0));
      plan.push_back(reg_row(CSR_DECAY,   16'd100));
      plan.push_back(reg_row(CSR_PERIOD0, 16'd1));
      plan.push_back(reg_row(CSR_PERIOD1, 16'd0));
      plan.push_back(reg_row(CSR_ENABLE,  16'd1));
      plan.push_back(beat_row(OP_PLUCK, 5'd0,  16'sd0,     1, 1'b0, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,    30, 1'b1, 16'sd0, 1'b0));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     1, 1'b1, 16'sh7FFF, 1'b0));
      plan.push_back(reg_row(CSR_ENABLE,  16'd3));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     1, 1'b1, 16'sh7FFF, 1'b1));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     1, 1'b1, 16'sh8000, 1'b1));
      plan.push_back(reg_row(CSR_DECAY,   16'd127));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,    30, 1'b0, 16'sd0, 1'b0));
      plan.push_back(reg_row(CSR_DECAY,   16'd0));
      plan.push_back(beat_row(OP_TICK,  5'd0,  16'sd0,     3, 1'b1, 16'sd0, 1'b0));

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            settle();
            write_reg(plan[i].reg_addr, plan[i].reg_data);
         end else begin
            repeat (plan[i].count)
               send_beat(plan[i].op, plan[i].idx, plan[i].val, plan[i].pinned, plan[i].want);
         end
      end

      // Random phases over several register settings; the last one runs flat out
      for (int ph = 0; ph < 6; ph++) begin
         replay = 1'b0;
         case (ph)
            0: begin
               set_decay = 16'd100; set_p0 = 16'd1; set_p1 = 16'd2; set_en = 16'd3;
               idle_pct = 20; stall_pct = 20; replay = 1'b1;
            end
            1: begin
               set_decay = 16'd127; set_p0 = 16'd1; set_p1 = 16'd1; set_en = 16'd3;
               idle_pct = 0; stall_pct = 0; replay = 1'b1;
            end
            2: begin
               set_decay = 16'd0; set_p0 = 16'd3; set_p1 = 16'd0; set_en = 16'd1;
               idle_pct = 40; stall_pct = 10;
            end
            3: begin
               set_decay = 16'd50; set_p0 = 16'd2; set_p1 = 16'd5; set_en = 16'd2;
               idle_pct = 10; stall_pct = 40; replay = 1'b1;
            end
            4: begin
               set_decay = CSR_DATA_W'($urandom_range(0, 127)); set_p0 = 16'hFFFF;
               set_p1 = 16'd1; set_en = 16'd0; idle_pct = 20; stall_pct = 20;
            end
            default: begin
               set_decay = CSR_DATA_W'($urandom_range(80, 127));
               set_p0    = CSR_DATA_W'($urandom_range(1, 4));
               set_p1    = CSR_DATA_W'($urandom_range(1, 4));
               set_en    = CSR_DATA_W'($urandom_range(0, 3));
               replay = 1'b1;
            end
         endcase
         settle();
         if (ph == 5) calm = 1'b1;
         write_reg(CSR_DECAY,   set_decay);
         write_reg(CSR_PERIOD0, set_p0);
         write_reg(CSR_PERIOD1, set_p1);
         write_reg(CSR_ENABLE,  set_en);
         if (replay) send_beat(OP_PLUCK, '0, '0, 1'b0, '0);
         play_random(105);
      end

      settle();
      if (mismatches == 0) begin
         $display("plucked_string_voice_synth_test: clean");
      end else begin
         $display("plucked_string_voice_synth_test: errors");
      end
      $finish;
   end

endmodule
